// ===== rtl/core/scl_pkg.sv =====
// shared types and constants for the sector cache lru controller
package scl_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_FLUSH = 2'd3;

    localparam logic [1:0] ACT_HIT       = 2'd0;
    localparam logic [1:0] ACT_FILL      = 2'd1;
    localparam logic [1:0] ACT_WRITEBACK = 2'd2;
    localparam logic [1:0] ACT_DONE      = 2'd3;

    localparam int SECTOR_BITS = 32;

    // what the controller tells the datapath in one cycle
    typedef struct packed {
        logic load_req;    // capture request and run the tag lookup
        logic touch_hit;   // hit: mark most recent, set dirty on write
        logic fill;        // miss: install request in the victim slot
        logic free_slot;   // invalidate the matching slot
        logic scan_start;  // flush: reset the walk pointer
        logic scan_step;   // flush: advance past the current slot
        logic scan_clean;  // flush: clean the current slot
    } dp_cmd_t;

    // what the datapath reports back
    typedef struct packed {
        logic       is_hit;
        logic       victim_dirty;
        logic       scan_dirty;
        logic       scan_end;
        logic       any_dirty_ahead;
    } dp_stat_t;

endpackage

// ===== rtl/core/scl_datapath.sv =====
// slot tags, lru ranks, dirty bits, lookup and flush walk
module scl_datapath #(
    parameter int SLOTS       = 64,
    parameter int DEVICE_BITS = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scl_pkg::dp_cmd_t                cmd,
    output scl_pkg::dp_stat_t               stat,
    input  logic [1:0]                      in_kind,
    input  logic [DEVICE_BITS-1:0]          in_device,
    input  logic [scl_pkg::SECTOR_BITS-1:0] in_sector,
    output logic [$clog2(SLOTS)-1:0]        hit_idx,
    output logic [$clog2(SLOTS)-1:0]        victim_idx,
    output logic [$clog2(SLOTS)-1:0]        scan_idx,
    output logic [DEVICE_BITS-1:0]          req_device,
    output logic [scl_pkg::SECTOR_BITS-1:0] req_sector,
    output logic [DEVICE_BITS-1:0]          victim_device,
    output logic [scl_pkg::SECTOR_BITS-1:0] victim_sector,
    output logic [DEVICE_BITS-1:0]          scan_device,
    output logic [scl_pkg::SECTOR_BITS-1:0] scan_sector
);
    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] TOP_RANK = IW'(SLOTS - 1);

    logic [SLOTS-1:0]                      valid_reg;
    logic [SLOTS-1:0]                      dirty_reg;
    logic [DEVICE_BITS-1:0]                dev_reg [SLOTS];
    logic [scl_pkg::SECTOR_BITS-1:0]       sec_reg [SLOTS];
    logic [IW-1:0]                         rank_reg [SLOTS];
    logic [SLOTS-1:0]                      match_reg;
    logic                                  is_write_reg;
    logic [DEVICE_BITS-1:0]                req_dev_reg;
    logic [scl_pkg::SECTOR_BITS-1:0]       req_sec_reg;
    logic [IW-1:0]                         hit_idx_reg;
    logic [IW-1:0]                         victim_idx_reg;
    logic [IW:0]                           scan_reg;
    logic [SLOTS-1:0]                      match_next;
    logic [IW-1:0]                         hit_pick;
    logic [IW-1:0]                         victim_pick;
    logic [IW-1:0]                         touch_idx;
    logic [IW-1:0]                         old_rank;
    logic                                  touch;
    logic [SLOTS-1:0]                      pend_dirty;

    // parallel tag compare, registered
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_next[i] = valid_reg[i] && dev_reg[i] == in_device
                            && sec_reg[i] == in_sector;
        end
    end

    // lowest matching slot and the rank-zero slot
    always_comb begin
        hit_pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                hit_pick = IW'(i);
            end
        end
        victim_pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (rank_reg[i] == '0) begin
                victim_pick = IW'(i);
            end
        end
    end

    assign touch     = cmd.touch_hit || cmd.fill;
    assign touch_idx = cmd.fill ? victim_idx_reg : hit_idx_reg;
    assign old_rank  = rank_reg[touch_idx];

    // dirty slots past the walk pointer
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            pend_dirty[i] = valid_reg[i] && dirty_reg[i] && (IW + 1)'(i) > scan_reg;
        end
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            scan_reg  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                rank_reg[i] <= IW'(i);
            end
        end else begin
            if (cmd.load_req) begin
                match_reg    <= match_next;
                is_write_reg <= in_kind == scl_pkg::KIND_WRITE;
                req_dev_reg  <= in_device;
                req_sec_reg  <= in_sector;
            end
            if (touch) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (rank_reg[i] > old_rank) begin
                        rank_reg[i] <= rank_reg[i] - 1'b1;
                    end
                end
                rank_reg[touch_idx] <= TOP_RANK;
            end
            if (cmd.touch_hit && is_write_reg) begin
                dirty_reg[hit_idx_reg] <= 1'b1;
            end
            if (cmd.fill) begin
                valid_reg[victim_idx_reg] <= 1'b1;
                dirty_reg[victim_idx_reg] <= is_write_reg;
                dev_reg[victim_idx_reg]   <= req_dev_reg;
                sec_reg[victim_idx_reg]   <= req_sec_reg;
            end
            if (cmd.free_slot) begin
                valid_reg[hit_idx_reg] <= 1'b0;
                dirty_reg[hit_idx_reg] <= 1'b0;
            end
            if (cmd.scan_start) begin
                scan_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.scan_clean) begin
                dirty_reg[scan_reg[IW-1:0]] <= 1'b0;
            end
        end
    end

    // pick registers, loaded in the cycle after the lookup
    always_ff @(posedge aclk) begin
        hit_idx_reg    <= hit_pick;
        victim_idx_reg <= victim_pick;
    end

    assign stat.is_hit          = |match_reg;
    assign stat.victim_dirty    = valid_reg[victim_idx_reg] && dirty_reg[victim_idx_reg];
    assign stat.scan_dirty      = valid_reg[scan_reg[IW-1:0]] && dirty_reg[scan_reg[IW-1:0]];
    assign stat.scan_end        = scan_reg[IW-1:0] == TOP_RANK;
    assign stat.any_dirty_ahead = |pend_dirty;

    assign hit_idx       = hit_idx_reg;
    assign victim_idx    = victim_idx_reg;
    assign scan_idx      = scan_reg[IW-1:0];
    assign req_device    = req_dev_reg;
    assign req_sector    = req_sec_reg;
    assign victim_device = dev_reg[victim_idx_reg];
    assign victim_sector = sec_reg[victim_idx_reg];
    assign scan_device   = dev_reg[scan_reg[IW-1:0]];
    assign scan_sector   = sec_reg[scan_reg[IW-1:0]];
endmodule

// ===== rtl/core/scl_control.sv =====
// request sequencer and result word register
module scl_control #(
    parameter int SLOTS       = 64,
    parameter int DEVICE_BITS = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_kind,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_action,
    output logic [$clog2(SLOTS)-1:0]        m_slot_index,
    output logic [DEVICE_BITS-1:0]          m_out_device,
    output logic [scl_pkg::SECTOR_BITS-1:0] m_out_sector,
    output logic                            m_found,
    output logic                            m_last,
    output scl_pkg::dp_cmd_t                cmd,
    input  scl_pkg::dp_stat_t               stat,
    input  logic [$clog2(SLOTS)-1:0]        hit_idx,
    input  logic [$clog2(SLOTS)-1:0]        victim_idx,
    input  logic [$clog2(SLOTS)-1:0]        scan_idx,
    input  logic [DEVICE_BITS-1:0]          req_device,
    input  logic [scl_pkg::SECTOR_BITS-1:0] req_sector,
    input  logic [DEVICE_BITS-1:0]          victim_device,
    input  logic [scl_pkg::SECTOR_BITS-1:0] victim_sector,
    input  logic [DEVICE_BITS-1:0]          scan_device,
    input  logic [scl_pkg::SECTOR_BITS-1:0] scan_sector
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_PICK, ST_DECIDE, ST_FILL, ST_FLUSH, ST_WAIT
    } state_t;

    localparam int IW = $clog2(SLOTS);

    state_t                          state_reg;
    logic [1:0]                      kind_reg;
    logic                            any_wb_reg;
    logic                            m_valid_reg;
    logic [1:0]                      act_reg;
    logic [IW-1:0]                   slot_reg;
    logic [DEVICE_BITS-1:0]          dev_reg;
    logic [scl_pkg::SECTOR_BITS-1:0] sec_reg;
    logic                            found_reg;
    logic                            last_reg;
    logic                            out_free;
    logic                            word_load;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == ST_IDLE;

    // datapath commands and result word load follow the state
    always_comb begin
        cmd = '0;
        word_load = 1'b0;
        cmd.load_req = s_valid && s_ready;
        unique case (state_reg)
            ST_IDLE: cmd.scan_start = 1'b1;
            ST_DECIDE: begin
                if (out_free) begin
                    word_load = 1'b1;
                    if (kind_reg == scl_pkg::KIND_FREE) begin
                        cmd.free_slot = stat.is_hit;
                    end else if (stat.is_hit) begin
                        cmd.touch_hit = 1'b1;
                    end else if (!stat.victim_dirty) begin
                        cmd.fill = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill  = out_free;
                word_load = out_free;
            end
            ST_FLUSH: begin
                if (out_free) begin
                    cmd.scan_step  = 1'b1;
                    cmd.scan_clean = stat.scan_dirty;
                    word_load      = stat.scan_dirty || (stat.scan_end && !any_wb_reg);
                end
            end
            default: ;
        endcase
    end

    // sequencer and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            any_wb_reg  <= 1'b0;
        end else begin
            m_valid_reg <= word_load || (m_valid_reg && !m_ready);
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= s_kind;
                        any_wb_reg <= 1'b0;
                        state_reg  <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    state_reg <= (kind_reg == scl_pkg::KIND_FLUSH) ? ST_FLUSH : ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        if (kind_reg == scl_pkg::KIND_FREE) begin
                            act_reg   <= scl_pkg::ACT_DONE;
                            slot_reg  <= stat.is_hit ? hit_idx : '0;
                            dev_reg   <= '0;
                            sec_reg   <= '0;
                            found_reg <= stat.is_hit;
                            last_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (stat.is_hit) begin
                            act_reg   <= scl_pkg::ACT_HIT;
                            slot_reg  <= hit_idx;
                            dev_reg   <= req_device;
                            sec_reg   <= req_sector;
                            found_reg <= 1'b0;
                            last_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (stat.victim_dirty) begin
                            act_reg   <= scl_pkg::ACT_WRITEBACK;
                            slot_reg  <= victim_idx;
                            dev_reg   <= victim_device;
                            sec_reg   <= victim_sector;
                            found_reg <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= ST_FILL;
                        end else begin
                            act_reg   <= scl_pkg::ACT_FILL;
                            slot_reg  <= victim_idx;
                            dev_reg   <= req_device;
                            sec_reg   <= req_sector;
                            found_reg <= 1'b0;
                            last_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FILL: begin
                    if (out_free) begin
                        act_reg     <= scl_pkg::ACT_FILL;
                        slot_reg    <= victim_idx;
                        dev_reg     <= req_device;
                        sec_reg     <= req_sector;
                        found_reg   <= 1'b0;
                        last_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        found_reg <= 1'b0;
                        if (stat.scan_dirty) begin
                            any_wb_reg  <= 1'b1;
                            act_reg     <= scl_pkg::ACT_WRITEBACK;
                            slot_reg    <= scan_idx;
                            dev_reg     <= scan_device;
                            sec_reg     <= scan_sector;
                            last_reg    <= stat.scan_end || !stat.any_dirty_ahead;
                            if (stat.scan_end || !stat.any_dirty_ahead) begin
                                state_reg <= ST_WAIT;
                            end
                        end else if (stat.scan_end) begin
                            if (!any_wb_reg) begin
                                act_reg     <= scl_pkg::ACT_DONE;
                                slot_reg    <= '0;
                                dev_reg     <= '0;
                                sec_reg     <= '0;
                                last_reg    <= 1'b1;
                            end
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = act_reg;
    assign m_slot_index = slot_reg;
    assign m_out_device = dev_reg;
    assign m_out_sector = sec_reg;
    assign m_found      = found_reg;
    assign m_last       = last_reg;
endmodule

// ===== rtl/core/sector_cache_lru_controller.sv =====
// top level: fully associative lru write-back sector cache controller
// read, write and free do the tag lookup, then register one result word;
// a miss that writes back gives a writeback word, then a fill word. a
// new request is taken after the last word is registered. flush walks
// the slots one a cycle unless the output stalls.
// synchronous active-low reset clears valid and dirty bits and sets
// each slot's lru rank to its index; tags need no reset.
module sector_cache_lru_controller #(
    parameter int SLOTS       = 64,
    parameter int DEVICE_BITS = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_kind,
    input  logic [DEVICE_BITS-1:0]          s_device_id,
    input  logic [scl_pkg::SECTOR_BITS-1:0] s_sector_number,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_action,
    output logic [$clog2(SLOTS)-1:0]        m_slot_index,
    output logic [DEVICE_BITS-1:0]          m_out_device,
    output logic [scl_pkg::SECTOR_BITS-1:0] m_out_sector,
    output logic                            m_found,
    output logic                            m_last
);
    localparam int IW = $clog2(SLOTS);

    scl_pkg::dp_cmd_t                cmd;
    scl_pkg::dp_stat_t               stat;
    logic [IW-1:0]                   hit_idx;
    logic [IW-1:0]                   victim_idx;
    logic [IW-1:0]                   scan_idx;
    logic [DEVICE_BITS-1:0]          req_device;
    logic [scl_pkg::SECTOR_BITS-1:0] req_sector;
    logic [DEVICE_BITS-1:0]          victim_device;
    logic [scl_pkg::SECTOR_BITS-1:0] victim_sector;
    logic [DEVICE_BITS-1:0]          scan_device;
    logic [scl_pkg::SECTOR_BITS-1:0] scan_sector;

    // datapath
    scl_datapath #(.SLOTS(SLOTS), .DEVICE_BITS(DEVICE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_kind(s_kind), .in_device(s_device_id), .in_sector(s_sector_number),
        .hit_idx(hit_idx), .victim_idx(victim_idx), .scan_idx(scan_idx),
        .req_device(req_device), .req_sector(req_sector),
        .victim_device(victim_device), .victim_sector(victim_sector),
        .scan_device(scan_device), .scan_sector(scan_sector)
    );

    // controller
    scl_control #(.SLOTS(SLOTS), .DEVICE_BITS(DEVICE_BITS)) u_ctl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .m_valid(m_valid), .m_ready(m_ready), .m_action(m_action),
        .m_slot_index(m_slot_index), .m_out_device(m_out_device),
        .m_out_sector(m_out_sector), .m_found(m_found), .m_last(m_last),
        .cmd(cmd), .stat(stat), .hit_idx(hit_idx), .victim_idx(victim_idx),
        .scan_idx(scan_idx), .req_device(req_device), .req_sector(req_sector),
        .victim_device(victim_device), .victim_sector(victim_sector),
        .scan_device(scan_device), .scan_sector(scan_sector)
    );

`ifndef SYNTHESIS
    // only free results report found
    a_found_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_action == scl_pkg::ACT_DONE)
        else $error("found set on non-free result");

    // hit and fill words always close their request
    a_hit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == scl_pkg::ACT_HIT || m_action == scl_pkg::ACT_FILL)
        |-> m_last)
        else $error("hit or fill not marked last");

    // a slot is never touched as a hit and filled in the same cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.fill && cmd.touch_hit))
        else $error("fill and hit touch together");
`endif
endmodule
